// ===== hdl/lwps_pkg.sv =====
package lwps_pkg;

  // Input item commands
  localparam logic [1:0] CMD_WINDOW      = 2'd0;
  localparam logic [1:0] CMD_FULL_SCREEN = 2'd1;
  localparam logic [1:0] CMD_PIXEL       = 2'd2;

  // Panel command bytes
  localparam logic [7:0] OP_COL_SET   = 8'h2a;
  localparam logic [7:0] OP_ROW_SET   = 8'h2b;
  localparam logic [7:0] OP_MEM_WRITE = 8'h2c;

  // Configuration port
  localparam int unsigned PADDR_W = 3;
  localparam logic REG_SCREEN_WIDTH  = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;
  localparam logic [15:0] SCREEN_WIDTH_RESET  = 16'd128;
  localparam logic [15:0] SCREEN_HEIGHT_RESET = 16'd128;

  // Job queue between front and back
  localparam int unsigned JOB_QUEUE_DEPTH = 4;

  // One job for the byte serializer. A window job uses all four words;
  // a pixel job carries the RGB565 word in col_start.
  typedef struct packed {
    logic        is_window;
    logic        done;
    logic [15:0] col_start;
    logic [15:0] col_end;
    logic [15:0] row_start;
    logic [15:0] row_end;
  } job_t;

endpackage

// ===== hdl/lwps_in_if.sv =====
interface lwps_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] x_start;
  logic [15:0] y_start;
  logic [15:0] win_width;
  logic [15:0] win_height;
  logic [31:0] pixel;

  modport source (
    output valid, cmd, x_start, y_start, win_width, win_height, pixel,
    input  ready
  );
  modport sink (
    input  valid, cmd, x_start, y_start, win_width, win_height, pixel,
    output ready
  );
endinterface

// ===== hdl/lwps_out_if.sv =====
interface lwps_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_command;
  logic       last;
  logic       window_done;

  modport source (
    output valid, out_byte, is_command, last, window_done,
    input  ready
  );
  modport sink (
    input  valid, out_byte, is_command, last, window_done,
    output ready
  );
endinterface

// ===== hdl/lwps_front.sv =====
module lwps_front (
  input  logic                clk,
  input  logic                rst,
  lwps_in_if.sink             in_stream,
  input  logic [15:0]         screen_width,
  input  logic [15:0]         screen_height,
  input  logic                job_full,
  output logic                job_push,
  output lwps_pkg::job_t      job
);

  logic [15:0] row_width, row_width_next;
  logic [15:0] cols_left, cols_left_next;
  logic [15:0] rows_left, rows_left_next;
  logic        window_active, window_active_next;

  logic        accept;
  logic [15:0] win_x, win_y, win_w, win_h;
  logic [15:0] rows_dec;

  assign in_stream.ready = !job_full;
  assign accept = in_stream.valid && in_stream.ready;

  // Full-screen windows start at the origin and take the panel size.
  always_comb begin
    if (in_stream.cmd == lwps_pkg::CMD_FULL_SCREEN) begin
      win_x = '0;
      win_y = '0;
      win_w = screen_width;
      win_h = screen_height;
    end else begin
      win_x = in_stream.x_start;
      win_y = in_stream.y_start;
      win_w = in_stream.win_width;
      win_h = in_stream.win_height;
    end
  end

  assign rows_dec = rows_left - 16'd1;

  always_comb begin
    row_width_next     = row_width;
    cols_left_next     = cols_left;
    rows_left_next     = rows_left;
    window_active_next = window_active;
    job_push           = 1'b0;
    job                = '0;
    unique case (in_stream.cmd) inside
      lwps_pkg::CMD_WINDOW, lwps_pkg::CMD_FULL_SCREEN: begin
        job_push           = accept;
        job.is_window      = 1'b1;
        job.col_start      = win_x;
        job.col_end        = win_x + win_w - 16'd1;
        job.row_start      = win_y;
        job.row_end        = win_y + win_h - 16'd1;
        row_width_next     = win_w;
        cols_left_next     = win_w;
        rows_left_next     = win_h;
        window_active_next = (win_w != '0) && (win_h != '0);
      end
      lwps_pkg::CMD_PIXEL: begin
        job_push      = accept;
        job.col_start = {in_stream.pixel[23:19], in_stream.pixel[15:10],
                         in_stream.pixel[7:3]};
        // advance the column and row counters; flag the final pixel
        if (window_active) begin
          if (cols_left <= 16'd1) begin
            cols_left_next = row_width;
            rows_left_next = rows_dec;
            if (rows_dec == '0) begin
              window_active_next = 1'b0;
              job.done           = 1'b1;
            end
          end else begin
            cols_left_next = cols_left - 16'd1;
          end
        end
      end
      default: begin
        // unknown command: drop it
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width     <= '0;
      cols_left     <= '0;
      rows_left     <= '0;
      window_active <= 1'b0;
    end else if (job_push) begin
      row_width     <= row_width_next;
      cols_left     <= cols_left_next;
      rows_left     <= rows_left_next;
      window_active <= window_active_next;
    end
  end

endmodule

// ===== hdl/lwps_fifo.sv =====
module lwps_fifo #(
  parameter int unsigned DEPTH = lwps_pkg::JOB_QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lwps_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output lwps_pkg::job_t head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  lwps_pkg::job_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wrap_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= wrap_inc(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== hdl/lwps_back.sv =====
module lwps_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  lwps_pkg::job_t head,
  output logic           pop,
  lwps_out_if.source     out_stream
);

  // Byte positions within a window job
  localparam logic [3:0] IDX_COL_CMD   = 4'd0;
  localparam logic [3:0] IDX_COL_S_HI  = 4'd1;
  localparam logic [3:0] IDX_COL_S_LO  = 4'd2;
  localparam logic [3:0] IDX_COL_E_HI  = 4'd3;
  localparam logic [3:0] IDX_COL_E_LO  = 4'd4;
  localparam logic [3:0] IDX_ROW_CMD   = 4'd5;
  localparam logic [3:0] IDX_ROW_S_HI  = 4'd6;
  localparam logic [3:0] IDX_ROW_S_LO  = 4'd7;
  localparam logic [3:0] IDX_ROW_E_HI  = 4'd8;
  localparam logic [3:0] IDX_ROW_E_LO  = 4'd9;
  localparam logic [3:0] IDX_MEM_WRITE = 4'd10;
  // Byte positions within a pixel job
  localparam logic [3:0] IDX_PIX_HI    = 4'd0;
  localparam logic [3:0] IDX_PIX_LO    = 4'd1;

  logic [3:0] idx;
  logic [7:0] byte_val;
  logic       cmd_flag, last_flag, done_flag;
  logic       advance;

  always_comb begin
    byte_val  = '0;
    cmd_flag  = 1'b0;
    last_flag = 1'b0;
    done_flag = 1'b0;
    if (head.is_window) begin
      unique case (idx)
        IDX_COL_CMD: begin
          byte_val = lwps_pkg::OP_COL_SET;
          cmd_flag = 1'b1;
        end
        IDX_COL_S_HI: byte_val = head.col_start[15:8];
        IDX_COL_S_LO: byte_val = head.col_start[7:0];
        IDX_COL_E_HI: byte_val = head.col_end[15:8];
        IDX_COL_E_LO: byte_val = head.col_end[7:0];
        IDX_ROW_CMD: begin
          byte_val = lwps_pkg::OP_ROW_SET;
          cmd_flag = 1'b1;
        end
        IDX_ROW_S_HI: byte_val = head.row_start[15:8];
        IDX_ROW_S_LO: byte_val = head.row_start[7:0];
        IDX_ROW_E_HI: byte_val = head.row_end[15:8];
        IDX_ROW_E_LO: byte_val = head.row_end[7:0];
        IDX_MEM_WRITE: begin
          byte_val  = lwps_pkg::OP_MEM_WRITE;
          cmd_flag  = 1'b1;
          last_flag = 1'b1;
        end
        default: begin
          byte_val = '0;
        end
      endcase
    end else begin
      // pixel: high byte first
      byte_val  = (idx == IDX_PIX_HI) ? head.col_start[15:8] : head.col_start[7:0];
      last_flag = (idx == IDX_PIX_LO);
      done_flag = head.done;
    end
  end

  assign advance = head_valid && (!out_stream.valid || out_stream.ready);
  assign pop     = advance && last_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_stream.valid <= 1'b0;
      idx              <= '0;
    end else if (advance) begin
      out_stream.valid <= 1'b1;
      idx              <= last_flag ? '0 : idx + 4'd1;
    end else if (out_stream.ready) begin
      out_stream.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_stream.out_byte    <= byte_val;
      out_stream.is_command  <= cmd_flag;
      out_stream.last        <= last_flag;
      out_stream.window_done <= done_flag;
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    idx <= IDX_MEM_WRITE)
    else $error("byte index past end of window job");

  a_pop_rewinds: assert property (@(posedge clk) disable iff (rst)
    pop |=> (idx == '0))
    else $error("byte index not rewound after job end");

  a_done_on_data: assert property (@(posedge clk) disable iff (rst)
    (out_stream.valid && out_stream.window_done) |-> !out_stream.is_command)
    else $error("window_done flagged on a command byte");

  a_last_cmd: assert property (@(posedge clk) disable iff (rst)
    (out_stream.valid && out_stream.is_command && out_stream.last)
      |-> (out_stream.out_byte == lwps_pkg::OP_MEM_WRITE))
    else $error("window job ended on a command other than memory write");

endmodule

// ===== hdl/lcd_window_pixel_streamer.sv =====
// Byte stream generator for an SPI display panel. Each input transaction is a
// window request (from its fields, or full-screen from the screen_width and
// screen_height registers) or one XRGB8888 pixel. A window emits 11 bytes:
// column set 0x2a with big-endian start/end, row set 0x2b with start/end, then
// memory write 0x2c; a pixel emits its RGB565 value as two data bytes, high
// byte first. Every byte carries is_command (panel D/C line inverted), last on
// the final byte of its input transaction, and window_done on both bytes of
// the window's final pixel. The front end takes one input transaction per
// cycle while the job queue (JOB_QUEUE_DEPTH entries) has room; the back end
// sends one byte per cycle through a registered output while a job is queued
// and the sink is ready. Command code 3 is dropped with no output. The two
// size registers sit at APB byte addresses 0 and 4, reset to 128, and the user
// must write them only while the streamer is idle; the block itself does not
// enforce this.
module lcd_window_pixel_streamer #(
  parameter int unsigned JOB_QUEUE_DEPTH = lwps_pkg::JOB_QUEUE_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst,
  lwps_in_if.sink                      in_stream,
  lwps_out_if.source                   out_stream,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lwps_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  logic [15:0]    screen_width;
  logic [15:0]    screen_height;
  logic           cfg_write;

  logic           job_push;
  logic           job_full;
  lwps_pkg::job_t job;
  logic           head_valid;
  lwps_pkg::job_t head;
  logic           job_pop;

  // Configuration: zero-wait APB, registers selected by address bit 2.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= lwps_pkg::SCREEN_WIDTH_RESET;
      screen_height <= lwps_pkg::SCREEN_HEIGHT_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == lwps_pkg::REG_SCREEN_WIDTH) begin
        screen_width <= pwdata[15:0];
      end else begin
        screen_height <= pwdata[15:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == lwps_pkg::REG_SCREEN_HEIGHT) begin
      prdata = {16'd0, screen_height};
    end else begin
      prdata = {16'd0, screen_width};
    end
  end

  // Front end: accept, track the window counters, build jobs.
  lwps_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_stream     (in_stream),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .job_full      (job_full),
    .job_push      (job_push),
    .job           (job)
  );

  // Hold pending jobs so input and output stall independently.
  lwps_fifo #(
    .DEPTH (JOB_QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (job_push),
    .push_job   (job),
    .full       (job_full),
    .pop        (job_pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // Back end: serialize each job into bytes, one per cycle while the output is not stalled.
  lwps_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (job_pop),
    .out_stream (out_stream)
  );

endmodule
